// ===== rtl/qrs_pkg.sv =====
package qrs_pkg;

    localparam int COEF_W   = 16;
    localparam int FRAC     = 16;
    localparam int ROOT_W   = 32;

    localparam int D_W      = 2 * COEF_W + 1;          // |b*b - 4ac|
    localparam int SQ_STAGES = (D_W + 1) / 2 + FRAC;   // one root bit per stage
    localparam int SR_W     = SQ_STAGES;
    localparam int RAD_W    = 2 * SQ_STAGES;
    localparam int REM_W    = SR_W + 3;
    localparam int N_W      = SR_W + 1;                // numerator magnitude
    localparam int X_W      = N_W + 2;                 // 2n + d
    localparam int DEN_W    = COEF_W + 1;              // divisor magnitude
    localparam int Y_W      = DEN_W + 1;               // 2d
    localparam int DV_STAGES = X_W;

    localparam logic [2:0] KIND_LINEAR  = 3'd0;
    localparam logic [2:0] KIND_NONE    = 3'd1;
    localparam logic [2:0] KIND_TWO     = 3'd2;
    localparam logic [2:0] KIND_DOUBLE  = 3'd3;
    localparam logic [2:0] KIND_COMPLEX = 3'd4;

    typedef struct packed {
        logic              a_neg;
        logic [COEF_W-1:0] a_mag;
        logic              b_neg;
        logic [COEF_W-1:0] b_mag;
        logic              c_neg;
        logic [COEF_W-1:0] c_mag;
        logic              d_neg;
        logic              d_zero;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [SR_W-1:0]  root;
        logic [RAD_W-1:0] rad;
    } t_sq;

    typedef struct packed {
        logic [Y_W-1:0] rem;
        logic [X_W-1:0] num;   // dividend bits shift out, quotient bits shift in
        logic [Y_W-1:0] den;
        logic           neg;
        logic           dz;
    } t_dv;

    function automatic t_sq sqrt_step(t_sq p);
        t_sq              n;
        logic [REM_W-1:0] rsh;
        logic [REM_W-1:0] trial;
        rsh   = {p.rem[REM_W-3:0], p.rad[RAD_W-1 -: 2]};
        trial = REM_W'({p.root, 2'b01});
        if (rsh >= trial) begin
            n.rem  = rsh - trial;
            n.root = {p.root[SR_W-2:0], 1'b1};
        end else begin
            n.rem  = rsh;
            n.root = {p.root[SR_W-2:0], 1'b0};
        end
        n.rad = p.rad << 2;
        return n;
    endfunction

    function automatic t_dv div_step(t_dv p);
        t_dv          n;
        logic [Y_W:0] t;
        t = {p.rem, p.num[X_W-1]};
        n = p;
        if (t >= {1'b0, p.den}) begin
            n.rem = Y_W'(t - {1'b0, p.den});
            n.num = {p.num[X_W-2:0], 1'b1};
        end else begin
            n.rem = t[Y_W-1:0];
            n.num = {p.num[X_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // signed-magnitude add, result magnitude N_W bits, zero is positive
    function automatic logic [N_W:0] sm_add(logic an, logic [N_W-1:0] am,
                                            logic bn, logic [N_W-1:0] bm);
        logic           rn;
        logic [N_W-1:0] rm;
        if (an == bn) begin
            rn = an;
            rm = am + bm;
        end else if (am >= bm) begin
            rn = an;
            rm = am - bm;
        end else begin
            rn = bn;
            rm = bm - am;
        end
        if (rm == '0) rn = 1'b0;
        return {rn, rm};
    endfunction

    function automatic t_dv div_init(logic nn, logic [N_W-1:0] nm,
                                     logic dn, logic [DEN_W-1:0] dm);
        t_dv r;
        r.rem = '0;
        r.num = {1'b0, nm, 1'b0} + X_W'(dm);
        r.den = {dm, 1'b0};
        r.neg = nn ^ dn;
        r.dz  = (dm == '0);
        return r;
    endfunction

endpackage

// ===== rtl/qrs_front.sv =====
module qrs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [qrs_pkg::COEF_W-1:0] i_a,
    input  logic [qrs_pkg::COEF_W-1:0] i_b,
    input  logic [qrs_pkg::COEF_W-1:0] i_c,
    output logic                      o_valid,
    output logic [qrs_pkg::D_W-1:0]   o_dmag,
    output qrs_pkg::t_side            o_side
);
    import qrs_pkg::*;

    logic [2:0]          r_v;
    t_side               r_s1, r_s2, r_s3;
    logic [2*COEF_W-1:0] r_bb, r_ac;
    logic [D_W-1:0]      r_dmag;
    t_side               n_s1, n_s3;
    logic [D_W-1:0]      n_dmag;
    logic [D_W:0]        bb_x, ac4_x;

    always_comb begin
        n_s1        = '0;
        n_s1.a_neg  = i_a[COEF_W-1];
        n_s1.b_neg  = i_b[COEF_W-1];
        n_s1.c_neg  = i_c[COEF_W-1];
        n_s1.a_mag  = i_a[COEF_W-1] ? (COEF_W)'(-i_a) : i_a;
        n_s1.b_mag  = i_b[COEF_W-1] ? (COEF_W)'(-i_b) : i_b;
        n_s1.c_mag  = i_c[COEF_W-1] ? (COEF_W)'(-i_c) : i_c;
    end

    always_comb begin
        bb_x  = (D_W+1)'(r_bb);
        ac4_x = {r_ac, 2'b00};
        n_s3  = r_s2;
        n_s3.d_neg = 1'b0;
        if (r_s2.a_neg != r_s2.c_neg) begin
            n_dmag = D_W'(bb_x + ac4_x);
        end else if (bb_x >= ac4_x) begin
            n_dmag = D_W'(bb_x - ac4_x);
        end else begin
            n_dmag = D_W'(ac4_x - bb_x);
            n_s3.d_neg = 1'b1;
        end
        n_s3.d_zero = (n_dmag == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= n_s1;
            r_s2   <= r_s1;
            r_bb   <= (2*COEF_W)'(r_s1.b_mag) * (2*COEF_W)'(r_s1.b_mag);
            r_ac   <= (2*COEF_W)'(r_s1.a_mag) * (2*COEF_W)'(r_s1.c_mag);
            r_s3   <= n_s3;
            r_dmag <= n_dmag;
        end
    end

    assign o_valid = r_v[2];
    assign o_dmag  = r_dmag;
    assign o_side  = r_s3;

endmodule

// ===== rtl/qrs_sqrt.sv =====
module qrs_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [qrs_pkg::D_W-1:0]  i_dmag,
    input  qrs_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [qrs_pkg::SR_W-1:0] o_root,
    output qrs_pkg::t_side           o_side
);
    import qrs_pkg::*;

    logic [SQ_STAGES-1:0] r_v;
    t_sq                  r_st   [SQ_STAGES];
    t_side                r_side [SQ_STAGES];
    t_sq                  n_st   [SQ_STAGES];
    t_sq                  head;

    always_comb begin
        head.rem  = '0;
        head.root = '0;
        head.rad  = RAD_W'(i_dmag) << (2 * FRAC);
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign n_st[k] = sqrt_step(head);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k]   <= n_st[k];
                    r_side[k] <= i_side;
                end
            end
        end else begin : g_rest
            assign n_st[k] = sqrt_step(r_st[k-1]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k]   <= n_st[k];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQ_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_st[SQ_STAGES-1].root;
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

// ===== rtl/qrs_div.sv =====
module qrs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  qrs_pkg::t_dv               i_req,
    output logic                       o_valid,
    output logic [qrs_pkg::ROOT_W-1:0] o_root,
    output logic                       o_sat
);
    import qrs_pkg::*;

    localparam logic [X_W-1:0] LIM_POS = X_W'((64'd1 << (ROOT_W - 1)) - 64'd1);
    localparam logic [X_W-1:0] LIM_NEG = X_W'(64'd1 << (ROOT_W - 1));

    logic [DV_STAGES-1:0] r_v;
    logic                 r_vf;
    t_dv                  r_st [DV_STAGES];
    t_dv                  n_st [DV_STAGES];
    logic [ROOT_W-1:0]    r_root, n_root;
    logic                 r_sat, n_sat;
    t_dv                  last;
    logic [X_W-1:0]       q, lim, qs;
    logic                 neg;

    for (genvar k = 0; k < DV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign n_st[k] = div_step(i_req);
        end else begin : g_rest
            assign n_st[k] = div_step(r_st[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // round was folded into the dividend; apply sign and clip here
    always_comb begin
        last   = r_st[DV_STAGES-1];
        q      = last.num;
        neg    = last.neg && (q != '0);
        lim    = neg ? LIM_NEG : LIM_POS;
        n_sat  = 1'b0;
        qs     = q;
        if (q > lim) begin
            qs    = lim;
            n_sat = 1'b1;
        end
        n_root = neg ? ROOT_W'(-qs) : ROOT_W'(qs);
        if (last.dz) begin
            n_root = '0;
            n_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[DV_STAGES-2:0], i_valid};
            r_vf <= r_v[DV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
            r_sat  <= n_sat;
        end
    end

    assign o_valid = r_vf;
    assign o_root  = r_root;
    assign o_sat   = r_sat;

endmodule

// ===== rtl/quadratic_root_solver_top.sv =====
// Quadratic root solver: a*x^2 + b*x + c = 0, coefficients signed Q8.8.
// Input channel: i_valid/o_ready with i_coef_a, i_coef_b, i_coef_c.
// Output channel: o_valid/i_ready with o_root_kind, o_root_one, o_root_two
// (signed Q16.16) and o_saturated.
// Kinds: linear, no solution, two real, double root, complex (real part and
// imaginary magnitude). Roots round to nearest, ties away from zero, and clip
// to the 32-bit range with o_saturated set.
// Stages in order: magnitudes, products and the discriminant; the square
// root (one root bit per stage); numerator forming; the two parallel
// dividers (one quotient bit per stage plus clip).
// Throughput is one request per cycle while the output is not stalled.
// The whole pipeline advances as one; when the output holds an untaken
// result and i_ready is low, every stage freezes and o_ready drops, so no
// request is lost or duplicated. Reset clears only the valid bits; the
// block is ready for requests once reset is released.
module quadratic_root_solver_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [15:0]         i_coef_a,
    input  logic signed [15:0]         i_coef_b,
    input  logic signed [15:0]         i_coef_c,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_root_kind,
    output logic signed [31:0]         o_root_one,
    output logic signed [31:0]         o_root_two,
    output logic                       o_saturated
);
    import qrs_pkg::*;

    logic              en;
    logic              fr_valid, sq_valid, dv1_valid, dv2_valid;
    logic [D_W-1:0]    fr_dmag;
    t_side             fr_side, sq_side;
    logic [SR_W-1:0]   sq_root;
    logic              r_pv;
    t_dv               r_req1, r_req2, n_req1, n_req2;
    logic [2:0]        r_kind, n_kind;
    logic [2:0]        r_kind_pipe [DV_STAGES+1];
    logic [ROOT_W-1:0] dv1_root, dv2_root;
    logic              dv1_sat, dv2_sat;
    logic              mb_neg;
    logic [N_W-1:0]    mb_mag, s_mag;
    logic [DEN_W-1:0]  a2;
    logic [N_W:0]      sum_p, sum_n;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_valid (fr_valid),
        .o_dmag  (fr_dmag),
        .o_side  (fr_side)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_dmag  (fr_dmag),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // pick numerator and divisor for each root
    always_comb begin
        mb_neg = !sq_side.b_neg && (sq_side.b_mag != '0);
        mb_mag = N_W'({sq_side.b_mag, {FRAC{1'b0}}});
        s_mag  = N_W'(sq_root);
        a2     = {sq_side.a_mag, 1'b0};
        sum_p  = sm_add(mb_neg, mb_mag, 1'b0, s_mag);
        sum_n  = sm_add(mb_neg, mb_mag, (s_mag != '0), s_mag);
        n_req1 = div_init(1'b0, '0, 1'b0, '0);
        n_req2 = div_init(1'b0, '0, 1'b0, '0);
        if (sq_side.a_mag == '0) begin
            if (sq_side.b_mag == '0) begin
                n_kind = KIND_NONE;
            end else begin
                n_kind = KIND_LINEAR;
                n_req1 = div_init(!sq_side.c_neg && (sq_side.c_mag != '0),
                                  N_W'({sq_side.c_mag, {FRAC{1'b0}}}),
                                  sq_side.b_neg, DEN_W'(sq_side.b_mag));
            end
        end else if (sq_side.d_zero) begin
            n_kind = KIND_DOUBLE;
            n_req1 = div_init(mb_neg, mb_mag, sq_side.a_neg, a2);
            n_req2 = n_req1;
        end else if (!sq_side.d_neg) begin
            n_kind = KIND_TWO;
            n_req1 = div_init(sum_p[N_W], sum_p[N_W-1:0], sq_side.a_neg, a2);
            n_req2 = div_init(sum_n[N_W], sum_n[N_W-1:0], sq_side.a_neg, a2);
        end else begin
            n_kind = KIND_COMPLEX;
            n_req1 = div_init(mb_neg, mb_mag, sq_side.a_neg, a2);
            n_req2 = div_init(1'b0, s_mag, 1'b0, a2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req1 <= n_req1;
            r_req2 <= n_req2;
            r_kind <= n_kind;
        end
    end

    for (genvar k = 0; k <= DV_STAGES; k++) begin : g_kind
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_kind_pipe[k] <= (k == 0) ? r_kind : r_kind_pipe[(k == 0) ? 0 : k-1];
            end
        end
    end

    qrs_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_req   (r_req1),
        .o_valid (dv1_valid),
        .o_root  (dv1_root),
        .o_sat   (dv1_sat)
    );

    qrs_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_req   (r_req2),
        .o_valid (dv2_valid),
        .o_root  (dv2_root),
        .o_sat   (dv2_sat)
    );

    assign o_valid     = dv1_valid;
    assign o_root_kind = r_kind_pipe[DV_STAGES];
    assign o_root_one  = dv1_root;
    assign o_root_two  = dv2_root;
    assign o_saturated = dv1_sat || dv2_sat;

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv1_valid == dv2_valid)
        else $error("divider lanes out of step");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_kind == KIND_NONE) |->
            (o_root_one == '0) && (o_root_two == '0) && !o_saturated)
        else $error("no-solution result carries roots");

    a_double_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_kind == KIND_DOUBLE) |-> o_root_one == o_root_two)
        else $error("double root differs");

    a_imag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_kind == KIND_COMPLEX) |-> !o_root_two[31])
        else $error("negative imaginary magnitude");

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        sat;
    } root_set_t;

    // rounded quotient n/d, ties away from zero, clipped to 32 bits
    function automatic logic [31:0] quot_round(input logic nneg, input logic [127:0] nmag,
                                               input logic dneg, input logic [127:0] dmag,
                                               inout logic sat);
        logic [127:0] q;
        logic         neg;
        logic [127:0] lim;
        if (dmag == 0) return 32'd0;
        q = (2 * nmag + dmag) / (2 * dmag);
        neg = (nneg != dneg) && q != 0;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function automatic root_set_t solve_roots(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
        root_set_t    o;
        logic signed [127:0] dv;
        logic [127:0] dm, s, am, bm, cm;
        logic         an, bn, cn, mbn, sn, srn;
        logic [127:0] smag;
        o = '{KIND_NONE, 32'd0, 32'd0, 1'b0};
        an = a < 0; bn = b < 0; cn = c < 0;
        am = an ? -128'(signed'(a)) : 128'(a);
        bm = bn ? -128'(signed'(b)) : 128'(b);
        cm = cn ? -128'(signed'(c)) : 128'(c);
        if (am == 0) begin
            if (bm != 0) begin
                o.kind = KIND_LINEAR;
                o.r1 = quot_round(!cn && cm != 0, cm << FRAC, bn, bm, o.sat);
            end
            return o;
        end
        dv = 128'(signed'(b)) * 128'(signed'(b)) - 4 * 128'(signed'(a)) * 128'(signed'(c));
        dm = dv < 0 ? -dv : dv;
        s = isqrt(dm << (2 * FRAC));
        mbn = !bn && bm != 0;
        if (dm == 0) begin
            o.kind = KIND_DOUBLE;
            o.r1 = quot_round(mbn, bm << FRAC, an, 2 * am, o.sat);
            o.r2 = o.r1;
        end else if (dv > 0) begin
            o.kind = KIND_TWO;
            for (int k = 0; k < 2; k++) begin
                sn = (k == 1) && s != 0;
                if (mbn == sn) begin
                    srn = mbn; smag = (bm << FRAC) + s;
                end else if ((bm << FRAC) >= s) begin
                    srn = mbn; smag = (bm << FRAC) - s;
                end else begin
                    srn = sn; smag = s - (bm << FRAC);
                end
                if (smag == 0) srn = 1'b0;
                if (k == 0) o.r1 = quot_round(srn, smag, an, 2 * am, o.sat);
                else o.r2 = quot_round(srn, smag, an, 2 * am, o.sat);
            end
        end else begin
            o.kind = KIND_COMPLEX;
            o.r1 = quot_round(mbn, bm << FRAC, an, 2 * am, o.sat);
            o.r2 = quot_round(1'b0, s, 1'b0, 2 * am, o.sat);
        end
        return o;
    endfunction

    class root_board;
        root_set_t pending[$];
        int        errors = 0;

        function void note_request(logic [15:0] a, logic [15:0] b, logic [15:0] c);
            pending.push_back(solve_roots(a, b, c));
        endfunction

        function void check_result(logic [2:0] k, logic [31:0] r1, logic [31:0] r2, logic s);
            root_set_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d", $time, k);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, e.kind, k); errors++;
            end
            if (r1 !== e.r1) begin
                $display("%0t: root_one exp %h got %h", $time, e.r1, r1); errors++;
            end
            if (r2 !== e.r2) begin
                $display("%0t: root_two exp %h got %h", $time, e.r2, r2); errors++;
            end
            if (s !== e.sat) begin
                $display("%0t: saturated exp %b got %b", $time, e.sat, s); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0;
    logic signed [15:0] i_coef_a = 0, i_coef_b = 0, i_coef_c = 0;
    logic        o_ready, o_valid, o_saturated;
    logic [2:0]  o_root_kind;
    logic signed [31:0] o_root_one, o_root_two;
    root_board   board = new();
    int          idle_cycles = 0;
    localparam int WATCHDOG = 20000;

    quadratic_root_solver_top dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_request(i_coef_a, i_coef_b, i_coef_c);
            if (o_valid && i_ready)
                board.check_result(o_root_kind, o_root_one, o_root_two, o_saturated);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > WATCHDOG) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern: long open stretches, then choppy stretches
    always @(negedge i_clk) begin
        int ph;
        ph = $urandom_range(0, 99);
        if (!i_rst_n) i_ready <= 0;
        else if (($time / 4000) % 3 == 0) i_ready <= 1;
        else i_ready <= ph < 60;
    end

    task automatic send_request(input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] c);
        i_coef_a <= a; i_coef_b <= b; i_coef_c <= c;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        int g;
        i_valid <= 0;
        g = $urandom_range(1, 12);
        repeat (g) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'($urandom_range(0, 7)) - 16'd3;
            4: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int burst;
        logic [15:0] a, b, c, k;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: linear, none, two real, double, complex, extremes
        send_request(16'h0000, 16'h0100, 16'h0200);
        send_request(16'h0000, 16'h0000, 16'h0300);
        send_request(16'h0000, 16'h0000, 16'h0000);
        send_request(16'h0100, 16'hFD00, 16'h0200);
        send_request(16'h0100, 16'hFE00, 16'h0100);
        send_request(16'h0100, 16'h0000, 16'h0100);
        send_request(16'h0100, 16'h0001, 16'h0000);
        send_request(16'h0001, 16'h7FFF, 16'h0001);
        send_request(16'h0001, 16'h8000, 16'h8000);
        send_request(16'h8000, 16'h8000, 16'h8000);
        send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(16'h0000, 16'h0001, 16'h7FFF);
        send_request(16'h0000, 16'h0001, 16'h8000);
        send_request(16'h0000, 16'hFFFF, 16'h8000);
        send_request(16'hFFFF, 16'h0000, 16'h0000);
        send_request(16'h0001, 16'h0002, 16'h0001);
        send_request(16'h8000, 16'h0000, 16'h7FFF);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
        pause_sender();
        for (int n = 0; n < 600; ) begin
            burst = $urandom_range(1, 30);
            for (int j = 0; j < burst; j++, n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // build an exact double root: a*(x-k)^2 style
                    a = 16'($urandom_range(1, 15)); k = 16'($urandom_range(0, 15)) - 16'd7;
                    b = 16'(-2) * a * k; c = a * k * k;
                end else begin
                    a = pick_coef(); b = pick_coef(); c = pick_coef();
                end
                send_request(a, b, c);
            end
            if ($urandom_range(0, 3) != 0) pause_sender();
        end
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
